/* sv/ctsch_pkg.sv */
// ----------------------------------------------------------------------------
// ctsch_pkg
// Shared constants, codes and controller/datapath interface types for the
// cooperative task scheduler.
// ----------------------------------------------------------------------------
package ctsch_pkg;

  // Table geometry and tick length
  localparam int MAX_TASKS = 8;
  localparam int TICK_MS   = 10;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // Reciprocal for ms -> tick conversion: floor(x / TICK_MS) = (x * RECIP_M) >> RECIP_SH
  localparam int RECIP_L  = $clog2(TICK_MS);
  localparam int RECIP_SH = 32 + RECIP_L;
  localparam logic [32:0] RECIP_M =
    33'(((64'd1 << RECIP_SH) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

  // Command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_DISP = 2'd2;
  localparam logic [1:0] CMD_DEL  = 2'd3;

  // Reply kinds
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_DISP = 2'd1;
  localparam logic [1:0] KIND_DEL  = 2'd2;

  // Reply status
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;       // capture the input transfer, rewind the walk pointer
    logic tick_step;  // count down the entry under the pointer
    logic disp_step;  // examine the entry under the pointer for dispatch
    logic do_add;     // append a task and reply
    logic do_del;     // delete a task and reply
    logic flush;      // send the held dispatch reply as the last one
  } ctl_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic at_end;              // walk pointer has reached the task count
    logic [CNT_W-1:0] count;   // current task count
  } dp_status_t;

endpackage

/* sv/ctsch_ctrl.sv */
// ----------------------------------------------------------------------------
// ctsch_ctrl
// Sequencer: accepts a command, then steps the datapath through the table
// walk or the single add/delete operation.
// ----------------------------------------------------------------------------
module ctsch_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [1:0]            command,
  input  ctsch_pkg::dp_status_t dp_status,
  output logic                  busy,
  output ctsch_pkg::ctl_cmd_t   ctl_cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TICK = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_DISP = 3'd3;
  localparam logic [2:0] S_DEL  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctl_cmd    = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl_cmd.load = 1'b1;
          unique case (command)
            ctsch_pkg::CMD_TICK: state_next = S_TICK;
            ctsch_pkg::CMD_ADD:  state_next = S_ADD;
            ctsch_pkg::CMD_DISP: state_next = S_DISP;
            ctsch_pkg::CMD_DEL:  state_next = S_DEL;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_TICK: begin
        if (dp_status.at_end) begin
          state_next = S_IDLE;
        end else begin
          ctl_cmd.tick_step = 1'b1;
        end
      end
      S_ADD: begin
        ctl_cmd.do_add = 1'b1;
        state_next     = S_IDLE;
      end
      S_DISP: begin
        if (dp_status.at_end) begin
          ctl_cmd.flush = 1'b1;
          state_next    = S_IDLE;
        end else begin
          ctl_cmd.disp_step = 1'b1;
        end
      end
      S_DEL: begin
        ctl_cmd.do_del = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* sv/ctsch_dpath.sv */
// ----------------------------------------------------------------------------
// ctsch_dpath
// Task table, walk pointer, ms-to-tick conversion and reply register.
// ----------------------------------------------------------------------------
module ctsch_dpath (
  input  logic                  clk,
  input  logic                  rst,
  input  ctsch_pkg::ctl_cmd_t   ctl_cmd,
  input  logic [31:0]           delay_ms,
  input  logic [31:0]           period_ms,
  input  logic [15:0]           task_tag,
  input  logic [2:0]            task_index,
  output ctsch_pkg::dp_status_t dp_status,
  output logic                  reply_valid,
  output logic [1:0]            reply_kind,
  output logic                  status,
  output logic [3:0]            slot,
  output logic [15:0]           tag,
  output logic                  last
);

  localparam int MT = ctsch_pkg::MAX_TASKS;
  localparam int CW = ctsch_pkg::CNT_W;
  localparam int IW = ctsch_pkg::IDX_W;

  // Task table
  logic [15:0] entry_tag     [MT];
  logic [31:0] entry_delay   [MT];
  logic [31:0] entry_period  [MT];
  logic [7:0]  entry_pending [MT];
  logic [CW-1:0] task_count;

  // Captured transfer
  logic [15:0] tag_q;
  logic [2:0]  index_q;
  logic [31:0] delay_q;
  logic [31:0] period_q;

  // Walk pointer and held dispatch reply
  logic [CW-1:0] ptr;
  logic          held_valid;
  logic [3:0]    held_slot;
  logic [15:0]   held_tag;

  // ms -> ticks by reciprocal multiply
  logic [64:0] delay_prod;
  logic [64:0] period_prod;
  assign delay_prod  = 65'(delay_ms)  * 65'(ctsch_pkg::RECIP_M);
  assign period_prod = 65'(period_ms) * 65'(ctsch_pkg::RECIP_M);

  // Entry under the pointer
  logic [IW-1:0] p;
  logic [IW-1:0] add_idx;
  logic [15:0]   tag_p;
  logic [31:0]   delay_p;
  logic [31:0]   period_p;
  logic [7:0]    pending_p;
  assign p         = ptr[IW-1:0];
  assign add_idx   = task_count[IW-1:0];
  assign tag_p     = entry_tag[p];
  assign delay_p   = entry_delay[p];
  assign period_p  = entry_period[p];
  assign pending_p = entry_pending[p];

  logic full;
  logic del_ok;
  logic run_p;
  assign full   = (task_count >= CW'(MT));
  assign del_ok = (8'(index_q) < 8'(task_count));
  assign run_p  = (pending_p != 8'd0);

  // Removal request: one-shot task dispatched, or a valid delete
  logic          rm_en;
  logic [CW-1:0] rm_idx;
  always_comb begin
    rm_en  = 1'b0;
    rm_idx = ptr;
    if (ctl_cmd.disp_step && run_p && (period_p == 32'd0)) begin
      rm_en = 1'b1;
    end else if (ctl_cmd.do_del && del_ok) begin
      rm_en  = 1'b1;
      rm_idx = CW'(index_q);
    end
  end

  // Capture the transfer
  always_ff @(posedge clk) begin
    if (ctl_cmd.load) begin
      tag_q    <= task_tag;
      index_q  <= task_index;
      delay_q  <= 32'(delay_prod >> ctsch_pkg::RECIP_SH);
      period_q <= 32'(period_prod >> ctsch_pkg::RECIP_SH);
    end
  end

  // Table update
  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= '0;
      for (int j = 0; j < MT; j++) begin
        entry_pending[j] <= 8'd0;
      end
    end else begin
      // append
      if (ctl_cmd.do_add && !full) begin
        entry_tag[add_idx]     <= tag_q;
        entry_delay[add_idx]   <= delay_q;
        entry_period[add_idx]  <= period_q;
        entry_pending[add_idx] <= 8'd0;
        task_count             <= task_count + CW'(1);
      end
      // countdown, reload and saturating pending count
      if (ctl_cmd.tick_step) begin
        if (delay_p != 32'd0) begin
          entry_delay[p] <= delay_p - 32'd1;
        end else begin
          entry_delay[p] <= period_p;
          if (pending_p != 8'hFF) begin
            entry_pending[p] <= pending_p + 8'd1;
          end
        end
      end
      // periodic task run: use up one pending run
      if (ctl_cmd.disp_step && run_p && (period_p != 32'd0)) begin
        entry_pending[p] <= pending_p - 8'd1;
      end
      // close up the table over the removed slot
      if (rm_en) begin
        for (int j = 0; j < MT - 1; j++) begin
          if ((j >= int'(rm_idx)) && (j + 1 < int'(task_count))) begin
            entry_tag[j]     <= entry_tag[j+1];
            entry_delay[j]   <= entry_delay[j+1];
            entry_period[j]  <= entry_period[j+1];
            entry_pending[j] <= entry_pending[j+1];
          end
        end
        for (int j = 0; j < MT; j++) begin
          if (j == int'(task_count) - 1) begin
            entry_pending[j] <= 8'd0;
          end
        end
        task_count <= task_count - CW'(1);
      end
    end
  end

  // Walk pointer: stays put after a removal, the next entry has moved in
  always_ff @(posedge clk) begin
    if (ctl_cmd.load) begin
      ptr <= '0;
    end else if (ctl_cmd.tick_step) begin
      ptr <= ptr + CW'(1);
    end else if (ctl_cmd.disp_step && !rm_en) begin
      ptr <= ptr + CW'(1);
    end
  end

  // Held dispatch reply: last is known only when the walk ends
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (ctl_cmd.disp_step && run_p) begin
      held_valid <= 1'b1;
      held_slot  <= 4'(ptr);
      held_tag   <= tag_p;
    end else if (ctl_cmd.flush) begin
      held_valid <= 1'b0;
    end
  end

  // Reply register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
    end else begin
      reply_valid <= 1'b0;
      if (ctl_cmd.do_add) begin
        reply_valid <= 1'b1;
        reply_kind  <= ctsch_pkg::KIND_ADD;
        last        <= 1'b1;
        if (full) begin
          status <= ctsch_pkg::ST_FAIL;
          slot   <= 4'd0;
          tag    <= 16'd0;
        end else begin
          status <= ctsch_pkg::ST_OK;
          slot   <= 4'(task_count);
          tag    <= tag_q;
        end
      end else if (ctl_cmd.do_del) begin
        reply_valid <= 1'b1;
        reply_kind  <= ctsch_pkg::KIND_DEL;
        tag         <= 16'd0;
        last        <= 1'b1;
        if (del_ok) begin
          status <= ctsch_pkg::ST_OK;
          slot   <= 4'(task_count - CW'(1));
        end else begin
          status <= ctsch_pkg::ST_FAIL;
          slot   <= 4'(task_count);
        end
      end else if (held_valid && ((ctl_cmd.disp_step && run_p) || ctl_cmd.flush)) begin
        reply_valid <= 1'b1;
        reply_kind  <= ctsch_pkg::KIND_DISP;
        status      <= ctsch_pkg::ST_OK;
        slot        <= held_slot;
        tag         <= held_tag;
        last        <= ctl_cmd.flush;
      end
    end
  end

  assign dp_status.at_end = (ptr >= task_count);
  assign dp_status.count  = task_count;

endmodule

/* sv/cooperative_task_scheduler.sv */
// ----------------------------------------------------------------------------
// cooperative_task_scheduler
// Time-triggered task table with tick, add, dispatch and delete commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Add and delete give
// one reply, strobed on reply_valid in the same cycle that busy falls. Tick
// and dispatch walk the table one entry per cycle; tick gives no reply,
// dispatch gives one reply per pending task, one per cycle at most, with last
// set on the final one. Each reply is on the ports for exactly one cycle and
// there is no way to hold it off, so the receiver must take every strobe. The
// next command may be given while the last reply is still on the ports.
// ----------------------------------------------------------------------------
module cooperative_task_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] delay_ms,
  input  logic [31:0] period_ms,
  input  logic [15:0] task_tag,
  input  logic [2:0]  task_index,
  output logic        reply_valid,
  output logic [1:0]  reply_kind,
  output logic        status,
  output logic [3:0]  slot,
  output logic [15:0] tag,
  output logic        last
);

  ctsch_pkg::ctl_cmd_t   ctl_cmd;
  ctsch_pkg::dp_status_t dp_status;

  // Sequencer
  ctsch_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .command   (command),
    .dp_status (dp_status),
    .busy      (busy),
    .ctl_cmd   (ctl_cmd)
  );

  // Table and reply datapath
  ctsch_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctl_cmd     (ctl_cmd),
    .delay_ms    (delay_ms),
    .period_ms   (period_ms),
    .task_tag    (task_tag),
    .task_index  (task_index),
    .dp_status   (dp_status),
    .reply_valid (reply_valid),
    .reply_kind  (reply_kind),
    .status      (status),
    .slot        (slot),
    .tag         (tag),
    .last        (last)
  );

  // Table never overflows
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    dp_status.count <= ctsch_pkg::CNT_W'(ctsch_pkg::MAX_TASKS))
    else $error("task count above table size");

  // A transfer always makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  // Add and delete replies are single and final
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (reply_valid && (reply_kind == ctsch_pkg::KIND_ADD ||
                     reply_kind == ctsch_pkg::KIND_DEL)) |-> last)
    else $error("add/delete reply without last");

  // Dispatch replies never fail
  a_disp_ok: assert property (@(posedge clk) disable iff (rst)
    (reply_valid && reply_kind == ctsch_pkg::KIND_DISP) |-> (status == ctsch_pkg::ST_OK))
    else $error("failed dispatch reply");

  // The final reply of a command leaves the block idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (reply_valid && last) |-> !$past(busy, 2) || !busy)
    else $error("busy after final reply");

endmodule

/* verif/ctsch_monitor.sv */
// ----------------------------------------------------------------------------
// ctsch_monitor
// Watches the command and reply channels of the task scheduler, keeps its own
// copy of the task table, predicts every reply and compares it field by field.
// ----------------------------------------------------------------------------
module ctsch_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] delay_ms,
  input  logic [31:0] period_ms,
  input  logic [15:0] task_tag,
  input  logic [2:0]  task_index,
  input  logic        reply_valid,
  input  logic [1:0]  reply_kind,
  input  logic        status,
  input  logic [3:0]  slot,
  input  logic [15:0] tag,
  input  logic        last,
  output int          fail_count,
  output int          open_replies
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  kind;
    logic        status;
    logic [3:0]  slot;
    logic [15:0] tag;
    logic        last;
  } reply_t;

  // Shadow task table
  logic [15:0] tbl_tag     [ctsch_pkg::MAX_TASKS];
  logic [31:0] tbl_delay   [ctsch_pkg::MAX_TASKS];
  logic [31:0] tbl_period  [ctsch_pkg::MAX_TASKS];
  logic [7:0]  tbl_pending [ctsch_pkg::MAX_TASKS];
  int unsigned tbl_count;

  reply_t due_replies[$];

  initial begin
    fail_count   = 0;
    open_replies = 0;
  end

  function automatic void queue_reply(input logic [1:0] kind, input logic st,
                                      input int unsigned s, input logic [15:0] t);
    reply_t r;
    r.kind   = kind;
    r.status = st;
    r.slot   = 4'(s);
    r.tag    = t;
    r.last   = 1'b0;
    due_replies.push_back(r);
  endfunction

  // Drop one entry and shift the rest down; the freed slot loses its runs
  function automatic void close_up(input int unsigned idx);
    for (int unsigned j = idx; j + 1 < tbl_count; j++) begin
      tbl_tag[j]     = tbl_tag[j+1];
      tbl_delay[j]   = tbl_delay[j+1];
      tbl_period[j]  = tbl_period[j+1];
      tbl_pending[j] = tbl_pending[j+1];
    end
    tbl_count--;
    tbl_pending[tbl_count] = 8'd0;
  endfunction

  // Apply one accepted command to the shadow table and queue its replies
  function automatic void run_command(input logic [1:0] cmd, input logic [31:0] dly,
                                      input logic [31:0] per, input logic [15:0] tg,
                                      input logic [2:0] idx);
    int unsigned i;
    int          first;
    first = due_replies.size();
    case (cmd)
      ctsch_pkg::CMD_TICK: begin
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_delay[i] != 0) begin
            tbl_delay[i]--;
          end else begin
            tbl_delay[i] = tbl_period[i];
            if (tbl_pending[i] != 8'hFF) tbl_pending[i]++;
          end
        end
      end
      ctsch_pkg::CMD_ADD: begin
        if (tbl_count < ctsch_pkg::MAX_TASKS) begin
          tbl_tag[tbl_count]     = tg;
          tbl_delay[tbl_count]   = dly / ctsch_pkg::TICK_MS;
          tbl_period[tbl_count]  = per / ctsch_pkg::TICK_MS;
          tbl_pending[tbl_count] = 8'd0;
          queue_reply(ctsch_pkg::KIND_ADD, ctsch_pkg::ST_OK, tbl_count, tg);
          tbl_count++;
        end else begin
          queue_reply(ctsch_pkg::KIND_ADD, ctsch_pkg::ST_FAIL, 0, 16'd0);
        end
      end
      ctsch_pkg::CMD_DISP: begin
        // one-shot tasks vanish at once; the entry that slides in is looked at next
        i = 0;
        while (i < tbl_count) begin
          if (tbl_pending[i] != 0) begin
            tbl_pending[i]--;
            queue_reply(ctsch_pkg::KIND_DISP, ctsch_pkg::ST_OK, i, tbl_tag[i]);
            if (tbl_period[i] == 0) close_up(i);
            else i++;
          end else begin
            i++;
          end
        end
      end
      default: begin
        if (idx < tbl_count) begin
          close_up(idx);
          queue_reply(ctsch_pkg::KIND_DEL, ctsch_pkg::ST_OK, tbl_count, 16'd0);
        end else begin
          queue_reply(ctsch_pkg::KIND_DEL, ctsch_pkg::ST_FAIL, tbl_count, 16'd0);
        end
      end
    endcase
    if (due_replies.size() > first) due_replies[$].last = 1'b1;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Replies are compared before the command of the same edge is applied
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      tbl_count = 0;
      foreach (tbl_pending[k]) tbl_pending[k] = 8'd0;
      due_replies.delete();
    end else begin
      if (reply_valid) begin
        if (due_replies.size() == 0) begin
          $error("reply with nothing expected: kind %0d slot %0d tag %0d",
                 reply_kind, slot, tag);
          fail_count++;
        end else begin
          want = due_replies.pop_front();
          check_field("reply_kind", want.kind, reply_kind);
          check_field("status", want.status, status);
          check_field("slot", want.slot, slot);
          check_field("tag", want.tag, tag);
          check_field("last", want.last, last);
        end
      end
      if (start && !busy) run_command(command, delay_ms, period_ms, task_tag, task_index);
    end
    open_replies <= due_replies.size();
  end

endmodule

/* verif/tb_cooperative_task_scheduler.sv */
// ----------------------------------------------------------------------------
// tb_cooperative_task_scheduler
// Drives directed and random tick, add, dispatch and delete commands into the
// scheduler with random gaps; the monitor predicts and checks every reply.
// ----------------------------------------------------------------------------
module tb_cooperative_task_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = ctsch_pkg::CMD_TICK;
  logic [31:0] delay_ms = '0;
  logic [31:0] period_ms = '0;
  logic [15:0] task_tag = '0;
  logic [2:0]  task_index = '0;
  logic        reply_valid;
  logic [1:0]  reply_kind;
  logic        status;
  logic [3:0]  slot;
  logic [15:0] tag;
  logic        last;
  int          fail_count;
  int          open_replies;
  int unsigned cycle_count = 0;
  bit          allow_gaps = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cooperative_task_scheduler dut (.*);

  ctsch_monitor u_monitor (.*);

  // Hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One command transfer; start stays high when the next one follows at once
  task automatic send(input logic [1:0] cmd, input logic [31:0] dly,
                      input logic [31:0] per, input logic [15:0] tg,
                      input logic [2:0] idx);
    if (allow_gaps && $urandom_range(0, 99) < 25) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start      <= 1'b1;
    command    <= cmd;
    delay_ms   <= dly;
    period_ms  <= per;
    task_tag   <= tg;
    task_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin
    int          r;
    logic [31:0] dly;
    logic [31:0] per;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, extremes, one-shot runs back to back, full table
    send(ctsch_pkg::CMD_DISP, '0, '0, '0, '0);
    send(ctsch_pkg::CMD_TICK, '0, '0, '0, '0);
    send(ctsch_pkg::CMD_DEL, '0, '0, '0, 3'd0);
    send(ctsch_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 3'd7);
    send(ctsch_pkg::CMD_ADD, 32'd0, 32'd0, 16'h0000, 3'd0);
    send(ctsch_pkg::CMD_ADD, 32'd15, 32'd25, 16'h1234, 3'd0);
    send(ctsch_pkg::CMD_ADD, 32'd9, 32'd9, 16'h5555, 3'd0);
    send(ctsch_pkg::CMD_TICK, '0, '0, '0, '0);
    send(ctsch_pkg::CMD_TICK, '0, '0, '0, '0);
    send(ctsch_pkg::CMD_DISP, '0, '0, '0, '0);
    for (int k = 0; k < 7; k++)
      send(ctsch_pkg::CMD_ADD, $urandom_range(0, 50), $urandom_range(0, 40),
           16'($urandom), '0);
    send(ctsch_pkg::CMD_DEL, '0, '0, '0, 3'd7);
    send(ctsch_pkg::CMD_DEL, '0, '0, '0, 3'd7);
    send(ctsch_pkg::CMD_DEL, '0, '0, '0, 3'd0);
    send(ctsch_pkg::CMD_TICK, '0, '0, '0, '0);
    send(ctsch_pkg::CMD_DISP, '0, '0, '0, '0);

    // Random mix with mostly short delays so tasks keep firing
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      allow_gaps = !(n >= 150 && n < 260);
      r = $urandom_range(0, 99);
      dly = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 80);
      case ($urandom_range(0, 9))
        0, 1, 2:       per = $urandom_range(0, 9);
        3, 4, 5, 6, 7: per = $urandom_range(10, 60);
        8:             per = $urandom();
        default:       per = 32'd0;
      endcase
      if (r < 40)
        send(ctsch_pkg::CMD_TICK, $urandom(), $urandom(), 16'($urandom), 3'($urandom));
      else if (r < 65)
        send(ctsch_pkg::CMD_ADD, dly, per, 16'($urandom), 3'($urandom));
      else if (r < 82)
        send(ctsch_pkg::CMD_DISP, $urandom(), $urandom(), 16'($urandom), 3'($urandom));
      else
        send(ctsch_pkg::CMD_DEL, dly, per, 16'($urandom), 3'($urandom_range(0, 7)));
    end

    start <= 1'b0;
    @(posedge clk);
    while (open_replies != 0) @(posedge clk);
    repeat (2 * ctsch_pkg::MAX_TASKS + 4) @(posedge clk);

    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
